@@ rtl/core/pse_pkg.sv @@
// ---------------------------------------------------------------------------
// Path span evaluator package
// Shared types, codes and helper functions for the path span evaluator.
// ---------------------------------------------------------------------------
package pse_pkg;

  // Width of the command position counter within one path.
  localparam int unsigned IndexBits = 16;

  // Curve parameter value that stands for 1.0.
  localparam logic [16:0] TOne = 17'd65536;

  // Command codes.
  localparam logic [2:0] FUNC_MOVE  = 3'd0;
  localparam logic [2:0] FUNC_LINE  = 3'd1;
  localparam logic [2:0] FUNC_QUAD  = 3'd2;
  localparam logic [2:0] FUNC_CUBIC = 3'd3;
  localparam logic [2:0] FUNC_CLOSE = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_SPAN    = 2'd0;
  localparam logic [1:0] ST_MOVE    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_NO_MOVE = 2'd3;

  // Last sequencer step for each phase and span kind.
  localparam logic [2:0] WtLastQuad   = 3'd2;
  localparam logic [2:0] WtLastCubic  = 3'd6;
  localparam logic [2:0] MacLastLine  = 3'd0;
  localparam logic [2:0] MacLastQuad  = 3'd4;
  localparam logic [2:0] MacLastCubic = 3'd6;

  // Arithmetic needed by an item.
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LINE,
    KIND_QUAD,
    KIND_CUBIC
  } kind_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_WEIGHT,
    S_MAC,
    S_FINISH,
    S_LOAD
  } state_e;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] ctrl1_x;
    logic signed [31:0] ctrl1_y;
    logic signed [31:0] ctrl2_x;
    logic signed [31:0] ctrl2_y;
    logic signed [31:0] ctrl3_x;
    logic signed [31:0] ctrl3_y;
    logic [16:0]        param_t;
    logic               last_cmd;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        cmd_index;
    logic signed [31:0] span_start_x;
    logic signed [31:0] span_start_y;
    logic signed [31:0] span_end_x;
    logic signed [31:0] span_end_y;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       accept;
    logic       wt_en;
    logic       mac_clear;
    logic       mac_en;
    logic       fin_en;
    logic       out_load;
    logic [2:0] step;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    kind_e kind;
  } dp_status_t;

  // Bernstein weights, all unsigned.
  typedef struct packed {
    logic [30:0] cw0;
    logic [30:0] cw1;
    logic [30:0] cw2;
    logic [30:0] cw3;
    logic [32:0] uu;
    logic [30:0] ut;
    logic [32:0] tt;
    logic [16:0] t;
    logic [16:0] u;
  } wts_t;

  // Saturate a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/core/path_span_bezier_evaluator_core.sv @@
// Each item is accepted, set up, passed through weight steps (quadratic and
// cubic spans only) and multiply-accumulate steps (not for move and error
// items), then finished and loaded into the output register. One item is
// worked on at a time: a new item is taken only once the last result is
// loaded. Reset is asynchronous, active low, and clears the path state,
// the sequencer and the output valid flag.
// ---------------------------------------------------------------------------
// Path span evaluator core
// Evaluates the span, point and tangent of path commands at parameter t.
// ---------------------------------------------------------------------------
module path_span_bezier_evaluator_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pse_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pse_pkg::out_item_t out_item_o
);

  pse_pkg::ctrl_cmd_t  cmd;
  pse_pkg::dp_status_t dp_status;

  // Sequencer.
  pse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  // Arithmetic and path state.
  pse_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .status_o   (dp_status),
    .out_item_o (out_item_o)
  );

endmodule

@@ rtl/core/pse_axis.sv @@
// ---------------------------------------------------------------------------
// Path span evaluator axis unit
// Multiply-accumulate over the Bernstein terms of one coordinate axis,
// followed by rounding and saturation of point and tangent.
// ---------------------------------------------------------------------------
module pse_axis (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pse_pkg::ctrl_cmd_t  cmd_i,
  input  pse_pkg::kind_e      kind_i,
  input  pse_pkg::wts_t       wts_i,
  input  logic signed [31:0]  p0_i,
  input  logic signed [31:0]  p1_i,
  input  logic signed [31:0]  p2_i,
  input  logic signed [31:0]  p3_i,
  input  logic signed [31:0]  end_i,
  output logic signed [31:0]  pt_o,
  output logic signed [31:0]  tg_o
);

  logic signed [32:0] d10, d21, d32, de;
  logic [30:0]        w_sel;
  logic signed [32:0] op_sel;
  logic               to_tan;
  logic signed [31:0] w_s;
  logic signed [64:0] prod;
  logic signed [65:0] accp_q, acct_q;
  logic signed [67:0] accp_w, acct_w, tg3, tg2;
  logic signed [67:0] rnd_p30, rnd_p16, rnd_t28, rnd_t16, line_pt, line_tg;
  logic signed [31:0] pt_d, tg_d, pt_q, tg_q;

  // Differences of successive control points.
  assign d10 = 33'(p1_i) - 33'(p0_i);
  assign d21 = 33'(p2_i) - 33'(p1_i);
  assign d32 = 33'(p3_i) - 33'(p2_i);
  assign de  = 33'(end_i) - 33'(p0_i);

  // Weight and operand for the current term.
  always_comb begin
    w_sel  = '0;
    op_sel = '0;
    to_tan = 1'b0;
    case (kind_i)
      pse_pkg::KIND_CUBIC: begin
        case (cmd_i.step)
          3'd0: begin w_sel = wts_i.cw0; op_sel = 33'(p0_i); end
          3'd1: begin w_sel = wts_i.cw1; op_sel = 33'(p1_i); end
          3'd2: begin w_sel = wts_i.cw2; op_sel = 33'(p2_i); end
          3'd3: begin w_sel = wts_i.cw3; op_sel = 33'(p3_i); end
          3'd4: begin w_sel = 31'(wts_i.uu >> 4); op_sel = d10; to_tan = 1'b1; end
          3'd5: begin w_sel = 31'(wts_i.ut >> 3); op_sel = d21; to_tan = 1'b1; end
          default: begin w_sel = 31'(wts_i.tt >> 4); op_sel = d32; to_tan = 1'b1; end
        endcase
      end
      pse_pkg::KIND_QUAD: begin
        case (cmd_i.step)
          3'd0: begin w_sel = 31'(wts_i.uu >> 2); op_sel = 33'(p0_i); end
          3'd1: begin w_sel = 31'(wts_i.ut >> 1); op_sel = 33'(p1_i); end
          3'd2: begin w_sel = 31'(wts_i.tt >> 2); op_sel = 33'(p2_i); end
          3'd3: begin w_sel = 31'(wts_i.u); op_sel = d10; to_tan = 1'b1; end
          default: begin w_sel = 31'(wts_i.t); op_sel = d21; to_tan = 1'b1; end
        endcase
      end
      pse_pkg::KIND_LINE: begin
        w_sel  = 31'(wts_i.t);
        op_sel = de;
      end
      default: begin
        w_sel  = '0;
        op_sel = '0;
      end
    endcase
  end

  assign w_s  = {1'b0, w_sel};
  assign prod = w_s * op_sel;

  // Point and tangent accumulators.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_clear) begin
      accp_q <= '0;
      acct_q <= '0;
    end else if (cmd_i.mac_en) begin
      if (to_tan) begin
        acct_q <= acct_q + 66'(prod);
      end else begin
        accp_q <= accp_q + 66'(prod);
      end
    end
  end

  // Rounding half up and saturation for each span kind.
  always_comb begin
    accp_w  = 68'(accp_q);
    acct_w  = 68'(acct_q);
    tg3     = acct_w + (acct_w <<< 1);
    tg2     = acct_w <<< 1;
    rnd_p30 = (accp_w + 68'sd536870912) >>> 30;
    rnd_p16 = (accp_w + 68'sd32768) >>> 16;
    rnd_t28 = (tg3 + 68'sd134217728) >>> 28;
    rnd_t16 = (tg2 + 68'sd32768) >>> 16;
    line_pt = 68'(p0_i) + rnd_p16;
    line_tg = 68'(end_i) - 68'(p0_i);
    case (kind_i)
      pse_pkg::KIND_CUBIC: begin
        pt_d = pse_pkg::sat32(rnd_p30);
        tg_d = pse_pkg::sat32(rnd_t28);
      end
      pse_pkg::KIND_QUAD: begin
        pt_d = pse_pkg::sat32(rnd_p30);
        tg_d = pse_pkg::sat32(rnd_t16);
      end
      pse_pkg::KIND_LINE: begin
        pt_d = pse_pkg::sat32(line_pt);
        tg_d = pse_pkg::sat32(line_tg);
      end
      default: begin
        pt_d = p0_i;
        tg_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q <= '0;
      tg_q <= '0;
    end else if (cmd_i.fin_en) begin
      pt_q <= pt_d;
      tg_q <= tg_d;
    end
  end

  assign pt_o = pt_q;
  assign tg_o = tg_q;

endmodule

@@ rtl/core/pse_datapath.sv @@
// ---------------------------------------------------------------------------
// Path span evaluator datapath
// Path state, item registers, shared weight multiplier, two axis units and
// the output register.
// ---------------------------------------------------------------------------
module pse_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pse_pkg::ctrl_cmd_t   cmd_i,
  input  pse_pkg::in_item_t    in_item_i,
  output pse_pkg::dp_status_t  status_o,
  output pse_pkg::out_item_t   out_item_o
);

  // Path state.
  logic signed [31:0] cursor_x_q, cursor_y_q, subpath_x_q, subpath_y_q;
  logic signed [31:0] cursor_x_d, cursor_y_d, subpath_x_d, subpath_y_d;
  logic               begun_q, begun_d;
  logic [pse_pkg::IndexBits-1:0] pos_q, pos_d;

  // Item registers.
  pse_pkg::kind_e     kind_q, kind_d;
  logic [1:0]         stat_q, stat_d;
  logic [pse_pkg::IndexBits-1:0] idx_q;
  logic signed [31:0] p0x_q, p0y_q, endx_q, endy_q, p0x_d, p0y_d, endx_d, endy_d;
  logic signed [31:0] p1x_q, p1y_q, p2x_q, p2y_q, p3x_q, p3y_q;
  logic [16:0]        t_d;

  // Weight unit.
  pse_pkg::wts_t      wts_q;
  logic [33:0]        ma;
  logic [16:0]        mb;
  logic [50:0]        wprod;
  logic [52:0]        wtrip;

  logic signed [31:0] ptx, pty, tgx, tgy;
  pse_pkg::out_item_t out_q;

  // Decode of the incoming item and the path state update.
  always_comb begin
    t_d         = (in_item_i.param_t > pse_pkg::TOne) ? pse_pkg::TOne : in_item_i.param_t;
    cursor_x_d  = cursor_x_q;
    cursor_y_d  = cursor_y_q;
    subpath_x_d = subpath_x_q;
    subpath_y_d = subpath_y_q;
    begun_d     = begun_q;
    kind_d      = pse_pkg::KIND_NONE;
    stat_d      = pse_pkg::ST_SPAN;
    p0x_d       = '0;
    p0y_d       = '0;
    endx_d      = '0;
    endy_d      = '0;
    if (in_item_i.func > pse_pkg::FUNC_CLOSE) begin
      stat_d = pse_pkg::ST_UNKNOWN;
    end else if (in_item_i.func == pse_pkg::FUNC_MOVE) begin
      stat_d      = pse_pkg::ST_MOVE;
      p0x_d       = in_item_i.ctrl1_x;
      p0y_d       = in_item_i.ctrl1_y;
      endx_d      = in_item_i.ctrl1_x;
      endy_d      = in_item_i.ctrl1_y;
      cursor_x_d  = in_item_i.ctrl1_x;
      cursor_y_d  = in_item_i.ctrl1_y;
      subpath_x_d = in_item_i.ctrl1_x;
      subpath_y_d = in_item_i.ctrl1_y;
      begun_d     = 1'b1;
    end else if (!begun_q) begin
      stat_d = pse_pkg::ST_NO_MOVE;
    end else begin
      p0x_d = cursor_x_q;
      p0y_d = cursor_y_q;
      case (in_item_i.func)
        pse_pkg::FUNC_LINE: begin
          kind_d = pse_pkg::KIND_LINE;
          endx_d = in_item_i.ctrl1_x;
          endy_d = in_item_i.ctrl1_y;
        end
        pse_pkg::FUNC_QUAD: begin
          kind_d = pse_pkg::KIND_QUAD;
          endx_d = in_item_i.ctrl2_x;
          endy_d = in_item_i.ctrl2_y;
        end
        pse_pkg::FUNC_CUBIC: begin
          kind_d = pse_pkg::KIND_CUBIC;
          endx_d = in_item_i.ctrl3_x;
          endy_d = in_item_i.ctrl3_y;
        end
        default: begin
          kind_d = pse_pkg::KIND_LINE;
          endx_d = subpath_x_q;
          endy_d = subpath_y_q;
        end
      endcase
      cursor_x_d = endx_d;
      cursor_y_d = endy_d;
    end
    pos_d = pos_q + 1'b1;
    if (in_item_i.last_cmd) begin
      cursor_x_d  = '0;
      cursor_y_d  = '0;
      subpath_x_d = '0;
      subpath_y_d = '0;
      begun_d     = 1'b0;
      pos_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q  <= '0;
      cursor_y_q  <= '0;
      subpath_x_q <= '0;
      subpath_y_q <= '0;
      begun_q     <= 1'b0;
      pos_q       <= '0;
      kind_q      <= pse_pkg::KIND_NONE;
    end else if (cmd_i.accept) begin
      cursor_x_q  <= cursor_x_d;
      cursor_y_q  <= cursor_y_d;
      subpath_x_q <= subpath_x_d;
      subpath_y_q <= subpath_y_d;
      begun_q     <= begun_d;
      pos_q       <= pos_d;
      kind_q      <= kind_d;
    end
  end

  // Item payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      stat_q  <= stat_d;
      idx_q   <= pos_q;
      p0x_q   <= p0x_d;
      p0y_q   <= p0y_d;
      endx_q  <= endx_d;
      endy_q  <= endy_d;
      p1x_q   <= in_item_i.ctrl1_x;
      p1y_q   <= in_item_i.ctrl1_y;
      p2x_q   <= in_item_i.ctrl2_x;
      p2y_q   <= in_item_i.ctrl2_y;
      p3x_q   <= in_item_i.ctrl3_x;
      p3y_q   <= in_item_i.ctrl3_y;
    end
  end

  // Shared weight multiplier: one product of t, u or their earlier products per step.
  always_comb begin
    case (cmd_i.step)
      3'd0: begin ma = 34'(wts_q.u); mb = wts_q.u; end
      3'd1: begin ma = 34'(wts_q.u); mb = wts_q.t; end
      3'd2: begin ma = 34'(wts_q.t); mb = wts_q.t; end
      3'd3: begin ma = 34'(wts_q.uu); mb = wts_q.u; end
      3'd4: begin ma = 34'(wts_q.uu); mb = wts_q.t; end
      3'd5: begin ma = 34'(wts_q.ut); mb = wts_q.t; end
      default: begin ma = 34'(wts_q.tt); mb = wts_q.t; end
    endcase
  end

  assign wprod = ma * mb;
  assign wtrip = 53'(wprod) + (53'(wprod) << 1);

  // Weight registers: t and u are taken with the item, the products follow.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      wts_q.t <= t_d;
      wts_q.u <= pse_pkg::TOne - t_d;
    end else if (cmd_i.wt_en) begin
      case (cmd_i.step)
        3'd0: wts_q.uu <= wprod[32:0];
        3'd1: wts_q.ut <= wprod[30:0];
        3'd2: wts_q.tt <= wprod[32:0];
        3'd3: wts_q.cw0 <= wprod[48:18];
        3'd4: wts_q.cw1 <= wtrip[48:18];
        3'd5: wts_q.cw2 <= wtrip[48:18];
        default: wts_q.cw3 <= wprod[48:18];
      endcase
    end
  end

  // Per-axis evaluation.
  pse_axis u_axis_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .kind_i (kind_q),
    .wts_i  (wts_q),
    .p0_i   (p0x_q),
    .p1_i   (p1x_q),
    .p2_i   (p2x_q),
    .p3_i   (p3x_q),
    .end_i  (endx_q),
    .pt_o   (ptx),
    .tg_o   (tgx)
  );

  pse_axis u_axis_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_i),
    .kind_i (kind_q),
    .wts_i  (wts_q),
    .p0_i   (p0y_q),
    .p1_i   (p1y_q),
    .p2_i   (p2y_q),
    .p3_i   (p3y_q),
    .end_i  (endy_q),
    .pt_o   (pty),
    .tg_o   (tgy)
  );

  // Output register, held until the result item is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.status       <= stat_q;
      out_q.cmd_index    <= 16'(idx_q);
      out_q.span_start_x <= p0x_q;
      out_q.span_start_y <= p0y_q;
      out_q.span_end_x   <= endx_q;
      out_q.span_end_y   <= endy_q;
      out_q.point_x      <= ptx;
      out_q.point_y      <= pty;
      out_q.tangent_x    <= tgx;
      out_q.tangent_y    <= tgy;
    end
  end

  assign status_o.kind = kind_q;
  assign out_item_o    = out_q;

endmodule

@@ rtl/core/pse_ctrl.sv @@
// ---------------------------------------------------------------------------
// Path span evaluator controller
// Sequences weight generation, multiply-accumulate, finishing and the
// output handshake for one item at a time.
// ---------------------------------------------------------------------------
module pse_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  pse_pkg::dp_status_t  status_i,
  output pse_pkg::ctrl_cmd_t   cmd_o
);

  pse_pkg::state_e state_q, state_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic [2:0]      wt_last, mac_last;
  logic            out_free;

  // Last step of each phase for the current span kind.
  always_comb begin
    case (status_i.kind)
      pse_pkg::KIND_CUBIC: begin
        wt_last  = pse_pkg::WtLastCubic;
        mac_last = pse_pkg::MacLastCubic;
      end
      pse_pkg::KIND_QUAD: begin
        wt_last  = pse_pkg::WtLastQuad;
        mac_last = pse_pkg::MacLastQuad;
      end
      default: begin
        wt_last  = pse_pkg::WtLastQuad;
        mac_last = pse_pkg::MacLastLine;
      end
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      pse_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = pse_pkg::S_SETUP;
        end
      end
      pse_pkg::S_SETUP: begin
        cnt_d = '0;
        case (status_i.kind)
          pse_pkg::KIND_NONE:  state_d = pse_pkg::S_FINISH;
          pse_pkg::KIND_LINE:  state_d = pse_pkg::S_MAC;
          default:             state_d = pse_pkg::S_WEIGHT;
        endcase
      end
      pse_pkg::S_WEIGHT: begin
        if (cnt_q == wt_last) begin
          cnt_d   = '0;
          state_d = pse_pkg::S_MAC;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      pse_pkg::S_MAC: begin
        if (cnt_q == mac_last) begin
          cnt_d   = '0;
          state_d = pse_pkg::S_FINISH;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      pse_pkg::S_FINISH: begin
        state_d = pse_pkg::S_LOAD;
      end
      pse_pkg::S_LOAD: begin
        if (out_free) begin
          state_d = pse_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = pse_pkg::S_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd_o           = '0;
    cmd_o.step      = cnt_q;
    in_ready_o      = 1'b0;
    case (state_q)
      pse_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      pse_pkg::S_SETUP:  cmd_o.mac_clear = 1'b1;
      pse_pkg::S_WEIGHT: cmd_o.wt_en     = 1'b1;
      pse_pkg::S_MAC:    cmd_o.mac_en    = 1'b1;
      pse_pkg::S_FINISH: cmd_o.fin_en    = 1'b1;
      pse_pkg::S_LOAD:   cmd_o.out_load  = out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // Output valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pse_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  // A finished result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten while full");

  // An accepted item always moves on to setup.
  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> state_q == pse_pkg::S_SETUP)
    else $error("accepted item did not enter setup");

  // Multiply-accumulate steps run only for items with a span to evaluate.
  a_mac_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mac_en |-> status_i.kind != pse_pkg::KIND_NONE)
    else $error("accumulate step for an item without a span");

  // Weights are generated only for curved spans.
  a_wt_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wt_en |-> (status_i.kind == pse_pkg::KIND_QUAD ||
                     status_i.kind == pse_pkg::KIND_CUBIC))
    else $error("weight step for a straight span");
`endif

endmodule
